// File: hdl/pafk_pkg.sv
package pafk_pkg;

  localparam int ANGLE_W   = 10;
  localparam int LEN_W     = 8;
  localparam int COORD_W   = 24;
  localparam int HEADING_W = 9;

  localparam int ROTATION_STEPS_DEF = 16;
  localparam int FRACTION_BITS_DEF  = 8;

  localparam int GUARD_BITS = 8;
  localparam int ANGLE_FRAC = 20;
  localparam int Z_W        = 29;
  localparam int ATAN_W     = 26;
  localparam int ATAN_LEN   = 24;

  localparam int GAIN_W    = 30;
  localparam int GAIN_FRAC = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

  localparam logic [HEADING_W-1:0] DEG_FULL = 9'd360;
  localparam logic [HEADING_W-1:0] DEG_90   = 9'd90;
  localparam logic [HEADING_W-1:0] DEG_180  = 9'd180;
  localparam logic [HEADING_W-1:0] DEG_270  = 9'd270;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [ATAN_W-1:0] ATAN_Q20 [ATAN_LEN] = '{
    26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121, 26'd3750058, 26'd1876857,
    26'd938658,   26'd469357,   26'd234682,   26'd117342,  26'd58671,   26'd29335,
    26'd14668,    26'd7334,     26'd3667,     26'd1833,    26'd917,     26'd458,
    26'd229,      26'd115,      26'd57,       26'd29,      26'd14,      26'd7
  };

  function automatic logic [HEADING_W-1:0] heading_wrap(
    input logic [HEADING_W-1:0]      head,
    input logic signed [ANGLE_W-1:0] ang
  );
    logic [HEADING_W+1:0] sum;
    sum = (HEADING_W+2)'(head) + (HEADING_W+2)'(ang) + (HEADING_W+2)'(720);
    for (int k = 0; k < 4; k++) begin
      if (sum >= (HEADING_W+2)'(DEG_FULL)) begin
        sum = sum - (HEADING_W+2)'(DEG_FULL);
      end
    end
    return sum[HEADING_W-1:0];
  endfunction

endpackage

// File: hdl/pafk_if.sv
interface pafk_in_if;
  import pafk_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      first_segment;
  logic signed [ANGLE_W-1:0] joint_angle_deg;
  logic [LEN_W-1:0]          segment_length;

  modport source (output valid, first_segment, joint_angle_deg, segment_length,
                  input ready);
  modport sink (input valid, first_segment, joint_angle_deg, segment_length,
                output ready);
endinterface

interface pafk_out_if;
  import pafk_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic [HEADING_W-1:0]      heading_deg;

  modport source (output valid, end_x, end_y, heading_deg, input ready);
  modport sink (input valid, end_x, end_y, heading_deg, output ready);
endinterface

// File: hdl/pafk_cell.sv
module pafk_cell #(
  parameter int STEP = 0,
  parameter int DP_W = 26
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic signed [DP_W-1:0]             in_x,
  input  logic signed [DP_W-1:0]             in_y,
  input  logic signed [pafk_pkg::Z_W-1:0]    in_z,
  output logic                               out_valid,
  output logic signed [DP_W-1:0]             out_x,
  output logic signed [DP_W-1:0]             out_y,
  output logic signed [pafk_pkg::Z_W-1:0]    out_z
);
  import pafk_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = Z_W'(ATAN_Q20[STEP]);

  logic                   valid_r;
  logic signed [DP_W-1:0] x_r;
  logic signed [DP_W-1:0] y_r;
  logic signed [Z_W-1:0]  z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      if (!in_z[Z_W-1]) begin
        x_r <= in_x - (in_y >>> STEP);
        y_r <= in_y + (in_x >>> STEP);
        z_r <= in_z - ATAN;
      end else begin
        x_r <= in_x + (in_y >>> STEP);
        y_r <= in_y - (in_x >>> STEP);
        z_r <= in_z + ATAN;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;

endmodule

// File: hdl/planar_arm_forward_kinematics.sv
// Planar arm forward kinematics. Each transfer on the input channel is one arm
// segment; each one yields exactly one result transfer with the new end point
// (signed, FRACTION_BITS fractional bits, saturated to 24 bits) and the
// cumulative heading in degrees 0..359. A set first_segment flag restarts the
// arm at the origin with heading zero. One segment is in flight at a time: it
// passes the gain multiply and quadrant split, the row of CORDIC cells (one
// micro-rotation per cell per cycle), rounding, the quadrant turn and the
// saturating add into the output register, which waits while an earlier result
// is not yet taken; only after that add can the next segment transfer. The
// output register lets the next segment transfer in while a result waits.
module planar_arm_forward_kinematics #(
  parameter int ROTATION_STEPS = pafk_pkg::ROTATION_STEPS_DEF,
  parameter int FRACTION_BITS  = pafk_pkg::FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pafk_in_if.sink    in_ch,
  pafk_out_if.source out_ch
);
  import pafk_pkg::*;

  localparam int STEP_COUNT = (ROTATION_STEPS > ATAN_LEN) ? ATAN_LEN : ROTATION_STEPS;
  localparam int WORK_BITS  = FRACTION_BITS + GUARD_BITS;
  localparam int DP_W       = LEN_W + WORK_BITS + 2;
  localparam int RW         = DP_W - GUARD_BITS;
  localparam int PROD_W     = LEN_W + GAIN_W;
  localparam int SHIFT      = GAIN_FRAC - WORK_BITS;
  localparam int SUM_W      = COORD_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_ROT  = 5'b00100,
    ST_TURN = 5'b01000,
    ST_ACC  = 5'b10000
  } pafk_state_t;

  pafk_state_t state_r;

  logic [HEADING_W-1:0] heading_r;
  logic [HEADING_W-1:0] heading_nxt;
  logic [LEN_W-1:0]     len_r;
  logic                 first_r;
  logic [1:0]           quad_nxt;
  logic [1:0]           quad_r;
  logic [HEADING_W-1:0] rest_nxt;
  logic [PROD_W-1:0]    prod;

  logic                   go_r;
  logic signed [DP_W-1:0] x0_r;
  logic signed [Z_W-1:0]  z0_r;

  logic                   cv [STEP_COUNT+1];
  logic signed [DP_W-1:0] cx [STEP_COUNT+1];
  logic signed [DP_W-1:0] cy [STEP_COUNT+1];
  logic signed [Z_W-1:0]  cz [STEP_COUNT+1];

  logic signed [DP_W-1:0] xr_sum;
  logic signed [DP_W-1:0] yr_sum;
  logic signed [RW-1:0]   rx_r;
  logic signed [RW-1:0]   ry_r;
  logic signed [RW-1:0]   dx_r;
  logic signed [RW-1:0]   dy_r;

  logic signed [COORD_W-1:0] point_x_r;
  logic signed [COORD_W-1:0] point_y_r;
  logic signed [COORD_W-1:0] base_x;
  logic signed [COORD_W-1:0] base_y;
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;
  logic signed [COORD_W-1:0] point_x_nxt;
  logic signed [COORD_W-1:0] point_y_nxt;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] end_x_r;
  logic signed [COORD_W-1:0] end_y_r;
  logic [HEADING_W-1:0]      heading_out_r;

  logic in_xfer;
  logic acc_go;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign acc_go      = (state_r == ST_ACC) && (!out_valid_r || out_ch.ready);

  assign heading_nxt = heading_wrap(in_ch.first_segment ? '0 : heading_r,
                                    in_ch.joint_angle_deg);

  always_comb begin
    if (heading_r >= DEG_270) begin
      quad_nxt = QUAD_3;
      rest_nxt = heading_r - DEG_270;
    end else if (heading_r >= DEG_180) begin
      quad_nxt = QUAD_2;
      rest_nxt = heading_r - DEG_180;
    end else if (heading_r >= DEG_90) begin
      quad_nxt = QUAD_1;
      rest_nxt = heading_r - DEG_90;
    end else begin
      quad_nxt = QUAD_0;
      rest_nxt = heading_r;
    end
  end

  assign prod = PROD_W'(len_r) * PROD_W'(GAIN_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      heading_r <= '0;
      go_r      <= 1'b0;
    end else begin
      go_r <= (state_r == ST_PREP);
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            heading_r <= heading_nxt;
            state_r   <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_r <= ST_ROT;
        end
        ST_ROT: begin
          if (cv[STEP_COUNT]) begin
            state_r <= ST_TURN;
          end
        end
        ST_TURN: begin
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          if (acc_go) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      len_r   <= in_ch.segment_length;
      first_r <= in_ch.first_segment;
    end
    if (state_r == ST_PREP) begin
      x0_r   <= DP_W'(prod >> SHIFT);
      z0_r   <= Z_W'(rest_nxt) <<< ANGLE_FRAC;
      quad_r <= quad_nxt;
    end
  end

  assign cv[0] = go_r;
  assign cx[0] = x0_r;
  assign cy[0] = '0;
  assign cz[0] = z0_r;

  for (genvar i = 0; i < STEP_COUNT; i++) begin : g_cell
    pafk_cell #(
      .STEP (i),
      .DP_W (DP_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_z      (cz[i]),
      .out_valid (cv[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_z     (cz[i+1])
    );
  end

  assign xr_sum = cx[STEP_COUNT] + DP_W'(1 << (GUARD_BITS - 1));
  assign yr_sum = cy[STEP_COUNT] + DP_W'(1 << (GUARD_BITS - 1));

  always_ff @(posedge clk) begin
    if (state_r == ST_ROT && cv[STEP_COUNT]) begin
      rx_r <= xr_sum[DP_W-1:GUARD_BITS];
      ry_r <= yr_sum[DP_W-1:GUARD_BITS];
    end
    if (state_r == ST_TURN) begin
      case (quad_r)
        QUAD_1: begin
          dx_r <= -ry_r;
          dy_r <= rx_r;
        end
        QUAD_2: begin
          dx_r <= -rx_r;
          dy_r <= -ry_r;
        end
        QUAD_3: begin
          dx_r <= ry_r;
          dy_r <= -rx_r;
        end
        default: begin
          dx_r <= rx_r;
          dy_r <= ry_r;
        end
      endcase
    end
  end

  assign base_x = first_r ? '0 : point_x_r;
  assign base_y = first_r ? '0 : point_y_r;
  assign sum_x  = SUM_W'(base_x) + SUM_W'(dx_r);
  assign sum_y  = SUM_W'(base_y) + SUM_W'(dy_r);

  always_comb begin
    if (sum_x[SUM_W-1] != sum_x[SUM_W-2]) begin
      point_x_nxt = sum_x[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                   : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      point_x_nxt = sum_x[COORD_W-1:0];
    end
    if (sum_y[SUM_W-1] != sum_y[SUM_W-2]) begin
      point_y_nxt = sum_y[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                   : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      point_y_nxt = sum_y[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_x_r   <= '0;
      point_y_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc_go) begin
        point_x_r   <= point_x_nxt;
        point_y_r   <= point_y_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_go) begin
      end_x_r       <= point_x_nxt;
      end_y_r       <= point_y_nxt;
      heading_out_r <= heading_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.end_x       = end_x_r;
  assign out_ch.end_y       = end_y_r;
  assign out_ch.heading_deg = heading_out_r;

endmodule
